// ===== sv/ita_pkg.sv =====
// Shared constants and helpers for the integer-to-ASCII radix converter.
package ita_pkg;

    // Default sizes
    localparam int DEF_MAX_DIGITS = 32;
    localparam int DEF_VALUE_BITS = 32;

    // Radix register
    localparam int          RADIX_W     = 6;
    localparam logic [5:0]  RADIX_RESET = 6'd10;
    localparam logic [5:0]  RADIX_MIN   = 6'd2;
    localparam logic [5:0]  RADIX_MAX   = 6'd36;
    localparam logic [5:0]  RADIX_DEC   = 6'd10;

    // Character codes
    localparam int          CHAR_W       = 7;
    localparam logic [6:0]  CHAR_ZERO    = 7'h30;
    localparam logic [6:0]  CHAR_LOWER_A = 7'h61;
    localparam logic [6:0]  CHAR_MINUS   = 7'h2D;
    localparam logic [5:0]  DIGIT_NINE   = 6'd9;
    localparam logic [6:0]  DIGIT_TEN    = 7'd10;

    // Clamp the programmed radix into 2..36
    function automatic logic [5:0] eff_radix(input logic [5:0] r);
        logic [5:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    // Digit value to lower-case ASCII
    function automatic logic [6:0] digit_char(input logic [5:0] d);
        logic [6:0] res;
        if (d > DIGIT_NINE) begin
            res = {1'b0, d} - DIGIT_TEN + CHAR_LOWER_A;
        end else begin
            res = {1'b0, d} + CHAR_ZERO;
        end
        return res;
    endfunction

endpackage

// ===== sv/int_to_ascii_radix.sv =====
// Integer to ASCII text converter with a programmable radix.
//
// Takes one signed integer word and returns its text in the programmed radix, one
// character word per output, most significant first, with o_last_char set on the
// final character. In radix 10 a negative value is led by '-'; in any other radix
// the value is read as unsigned. Digits come from a bit-serial restoring divider
// that yields one quotient bit per cycle; each character then takes two steps
// (digit store read, output load) and a sign one output load, and each output
// load waits while the output is stalled. The input stall is held for the whole
// conversion; the last character may still wait in the output register while
// the next word is accepted. The radix register must be written only while the
// block is idle; the block itself does not enforce this.
module int_to_ascii_radix #(
    parameter int MAX_DIGITS = ita_pkg::DEF_MAX_DIGITS,
    parameter int VALUE_BITS = ita_pkg::DEF_VALUE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic signed [VALUE_BITS-1:0]        i_value,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [ita_pkg::RADIX_W-1:0]         i_cfg_data,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [ita_pkg::CHAR_W-1:0]          o_text_char,
    output logic                                o_last_char
);

    localparam int IDX_W  = $clog2(MAX_DIGITS);
    localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
    localparam int STEP_W = $clog2(VALUE_BITS);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_BITS - 1);
    localparam logic [CNT_W:0]    CNT_LIMIT = (CNT_W + 1)'(MAX_DIGITS);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_SIGN,
        S_READ,
        S_LOAD
    } t_state;

    t_state                         r_state;
    logic [ita_pkg::RADIX_W-1:0]    r_radix_cfg;
    logic [ita_pkg::RADIX_W-1:0]    r_base;
    logic [VALUE_BITS-1:0]          r_quo;      // remaining magnitude / quotient
    logic [ita_pkg::RADIX_W-1:0]    r_rem;
    logic [STEP_W-1:0]              r_step;
    logic [CNT_W-1:0]               r_cnt;
    logic                           r_neg;
    logic [IDX_W-1:0]               r_idx;
    logic [ita_pkg::RADIX_W-1:0]    r_rd;
    logic                           r_ovalid;
    logic [ita_pkg::CHAR_W-1:0]     r_char;
    logic                           r_last;

    logic [ita_pkg::RADIX_W-1:0]    digit_mem [MAX_DIGITS];

    // Accept-time decode
    logic [VALUE_BITS-1:0]          val_u;
    logic [ita_pkg::RADIX_W-1:0]    base_in;
    logic                           neg_in;
    logic [VALUE_BITS-1:0]          mag_in;
    logic                           in_acc;

    // Divider step
    logic [ita_pkg::RADIX_W:0]      rem_sh;
    logic                           q_bit;
    logic [ita_pkg::RADIX_W:0]      rem_sub;
    logic [ita_pkg::RADIX_W-1:0]    n_rem;
    logic [VALUE_BITS-1:0]          n_quo;
    logic                           digit_done;
    logic [CNT_W:0]                 cnt_chk;
    logic                           more_digits;

    logic                           out_free;
    logic [ita_pkg::CHAR_W-1:0]     rd_char;

    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_text_char = r_char;
    assign o_last_char = r_last;
    assign out_free    = !r_ovalid || !i_stall;

    // Sign handling: only radix 10 reads the value as signed
    always_comb begin
        val_u   = i_value;
        base_in = ita_pkg::eff_radix(r_radix_cfg);
        neg_in  = (base_in == ita_pkg::RADIX_DEC) && val_u[VALUE_BITS-1];
        mag_in  = neg_in ? (~val_u + VALUE_BITS'(1)) : val_u;
    end

    // One restoring division step: shift in next dividend bit, trial subtract
    always_comb begin
        rem_sh      = {r_rem, r_quo[VALUE_BITS-1]};
        rem_sub     = rem_sh - {1'b0, r_base};
        q_bit       = (rem_sh >= {1'b0, r_base});
        n_rem       = q_bit ? rem_sub[ita_pkg::RADIX_W-1:0] : rem_sh[ita_pkg::RADIX_W-1:0];
        n_quo       = {r_quo[VALUE_BITS-2:0], q_bit};
        digit_done  = (r_state == S_DIV) && (r_step == STEP_LAST);
        cnt_chk     = {1'b0, r_cnt} + (CNT_W + 1)'(1) + (CNT_W + 1)'(r_neg);
        more_digits = (n_quo != '0) && (cnt_chk < CNT_LIMIT);
    end

    assign rd_char = ita_pkg::digit_char(r_rd);

    // Digit store, least significant digit at entry 0
    always_ff @(posedge i_clk) begin
        if (digit_done) begin
            digit_mem[r_cnt[IDX_W-1:0]] <= n_rem;
        end
        if (r_state == S_READ) begin
            r_rd <= digit_mem[r_idx];
        end
    end

    // Sequencer, divider registers and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix_cfg <= ita_pkg::RADIX_RESET;
            r_quo       <= '0;
            r_cnt       <= '0;
            r_neg       <= 1'b0;
            r_ovalid    <= 1'b0;
            r_step      <= '0;
            r_rem       <= '0;
            r_idx       <= '0;
            r_base      <= ita_pkg::RADIX_DEC;
            r_char      <= '0;
            r_last      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_radix_cfg <= i_cfg_data;
            end

            // output word leaves when taken
            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_base  <= base_in;
                        r_neg   <= neg_in;
                        r_quo   <= mag_in;
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_quo  <= n_quo;
                    r_rem  <= n_rem;
                    r_step <= r_step + STEP_W'(1);
                    if (r_step == STEP_LAST) begin
                        r_rem  <= '0;
                        r_step <= '0;
                        if (more_digits) begin
                            r_cnt <= r_cnt + CNT_W'(1);
                        end else begin
                            r_idx   <= r_cnt[IDX_W-1:0];
                            r_state <= r_neg ? S_SIGN : S_READ;
                        end
                    end
                end
                S_SIGN: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_char   <= ita_pkg::CHAR_MINUS;
                        r_last   <= 1'b0;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_char   <= rd_char;
                        r_last   <= (r_idx == '0);
                        if (r_idx == '0) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx - IDX_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
